FILE: hdl/cpce_pkg.sv
package cpce_pkg;

  localparam int unsigned HdrLen = 8;
  localparam int unsigned HdrIdxW = 4;

  localparam logic [7:0] UpperA = 8'd65;
  localparam logic [7:0] UpperZ = 8'd90;
  localparam logic [7:0] LowerA = 8'd97;
  localparam logic [7:0] LowerZ = 8'd122;
  localparam logic [7:0] CaseOffset = 8'd32;
  localparam logic [5:0] Alpha = 6'd26;
  localparam logic [15:0] CsumGood = 16'hFFFF;

  localparam logic KindPayload = 1'b0;
  localparam logic KindSummary = 1'b1;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StCsumErr = 2'd1,
    StLenErr  = 2'd2,
    StOpErr   = 2'd3
  } status_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic [15:0] new_checksum;
    status_e     status;
    logic        last;
  } result_t;

  // up to two results from one accepted byte, r0 goes out first
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  // ones-complement 16-bit add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

  // byte mod 26 by reciprocal multiply, exact for all 8-bit inputs
  function automatic logic [4:0] mod26(input logic [7:0] b);
    logic [16:0] prod;
    logic [3:0]  q;
    logic [7:0]  q26;
    logic [7:0]  r;
    prod = {9'd0, b} * 17'd316;
    q    = prod[16:13];
    q26  = {4'd0, q} * 8'd26;
    r    = b - q26;
    return r[4:0];
  endfunction

  function automatic logic [7:0] cipher_byte(input logic [7:0] c, input logic [4:0] k,
                                             input logic fwd);
    logic [7:0] lc;
    logic [7:0] off;
    logic [5:0] t;
    logic [7:0] res;
    lc = c;
    if (c >= UpperA && c <= UpperZ) begin
      lc = c + CaseOffset;
    end
    res = lc;
    if (lc >= LowerA && lc <= LowerZ) begin
      off = lc - LowerA;
      if (fwd) begin
        t = off[5:0] + {1'b0, k};
      end else begin
        t = off[5:0] + Alpha - {1'b0, k};
      end
      if (t >= Alpha) begin
        t = t - Alpha;
      end
      res = {2'b00, t} + LowerA;
    end
    return res;
  endfunction

endpackage

FILE: hdl/cpce_msg_core.sv
module cpce_msg_core
  import cpce_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  output push_t      push_o
);

  logic [HdrIdxW-1:0] hdr_idx_q, hdr_idx_d;
  logic [7:0]         op_q, op_d;
  logic [4:0]         k_q, k_d;
  logic [15:0]        rc_q, rc_d;
  logic [23:0]        len_hi_q, len_hi_d;
  logic [31:0]        len_m9_q, len_m9_d;
  logic [31:0]        cnt_q, cnt_d;
  logic [15:0]        isum_q, isum_d;
  logic [15:0]        osum_q, osum_d;
  logic [7:0]         pin_q, pin_d;
  logic [7:0]         pout_q, pout_d;
  logic               zero_q, zero_d;

  logic [7:0]  b;
  logic [15:0] hdr_word;
  logic [15:0] hdr_sum;
  logic [31:0] full_len;
  logic        zero_now;
  logic        odd;
  logic        fin;
  logic [7:0]  c;
  logic [15:0] in_op;
  logic [15:0] out_op;
  logic [15:0] isum_n;
  logic [15:0] osum_n;
  logic [15:0] chk;
  status_e     st;
  result_t     pay_res;
  result_t     sum_res;

  assign b = data_byte_i;

  always_comb begin
    hdr_idx_d = hdr_idx_q;
    op_d      = op_q;
    k_d       = k_q;
    rc_d      = rc_q;
    len_hi_d  = len_hi_q;
    len_m9_d  = len_m9_q;
    cnt_d     = cnt_q;
    isum_d    = isum_q;
    osum_d    = osum_q;
    pin_d     = pin_q;
    pout_d    = pout_q;
    zero_d    = zero_q;
    push_o    = '0;

    hdr_word = hdr_idx_q[0] ? {b, 8'd0} : {8'd0, b};
    hdr_sum  = oc_add(isum_q, hdr_word);
    full_len = {len_hi_q, b};

    zero_now = zero_q || (b == 8'd0);
    odd      = cnt_q[0];
    fin      = (cnt_q == len_m9_q);
    c        = zero_now ? b : cipher_byte(b, k_q, op_q == 8'd0);

    // pick the word each sum takes this byte; a zero adds only a held half word
    in_op  = 16'd0;
    out_op = 16'd0;
    if (zero_now) begin
      if (!zero_q && odd) begin
        in_op  = {8'd0, pin_q};
        out_op = {8'd0, pout_q};
      end
    end else if (odd) begin
      in_op  = {b, pin_q};
      out_op = {c, pout_q};
    end else if (fin) begin
      // message ends on a half word, flush it now
      in_op  = {8'd0, b};
      out_op = {8'd0, c};
    end
    isum_n = oc_add(isum_q, in_op);
    osum_n = oc_add(osum_q, out_op);

    pay_res              = '0;
    pay_res.kind         = KindPayload;
    pay_res.out_byte     = c;
    pay_res.status       = StOk;

    if (hdr_idx_q != HdrIdxW'(HdrLen)) begin
      chk = hdr_sum + rc_q;
      priority if (chk != CsumGood) st = StCsumErr;
      else if (full_len != 32'(HdrLen)) st = StLenErr;
      else if (op_q > 8'd1) st = StOpErr;
      else st = StOk;
    end else begin
      chk = isum_n + rc_q;
      priority if (chk != CsumGood) st = StCsumErr;
      else if (zero_now) st = StLenErr;
      else if (op_q > 8'd1) st = StOpErr;
      else st = StOk;
    end

    sum_res              = '0;
    sum_res.kind         = KindSummary;
    sum_res.out_byte     = 8'd0;
    sum_res.new_checksum = (hdr_idx_q != HdrIdxW'(HdrLen)) ? ~hdr_sum : ~osum_n;
    sum_res.status       = st;
    sum_res.last         = 1'b1;

    if (accept_i) begin
      if (hdr_idx_q != HdrIdxW'(HdrLen)) begin
        hdr_idx_d = hdr_idx_q + HdrIdxW'(1);
        unique case (hdr_idx_q[2:0])
          3'd0: op_d = b;
          3'd1: k_d = mod26(b);
          3'd2: rc_d[7:0] = b;
          3'd3: rc_d[15:8] = b;
          3'd4: len_hi_d[23:16] = b;
          3'd5: len_hi_d[15:8] = b;
          3'd6: len_hi_d[7:0] = b;
          default: ;
        endcase
        if (hdr_idx_q[2:1] != 2'd1) begin
          isum_d = hdr_sum;
        end
        if (hdr_idx_q[2:0] == 3'd7) begin
          len_m9_d = full_len - 32'(HdrLen + 1);
          osum_d   = hdr_sum;
          if (full_len <= 32'(HdrLen)) begin
            push_o.n  = 2'd1;
            push_o.r0 = sum_res;
            hdr_idx_d = '0;
            cnt_d     = '0;
            isum_d    = '0;
            osum_d    = '0;
            pin_d     = '0;
            pout_d    = '0;
            zero_d    = 1'b0;
          end
        end
      end else begin
        push_o.r0 = pay_res;
        zero_d    = zero_now;
        isum_d    = isum_n;
        osum_d    = osum_n;
        cnt_d     = cnt_q + 32'd1;
        if (!zero_now && !odd) begin
          pin_d  = b;
          pout_d = c;
        end
        if (fin) begin
          push_o.n  = 2'd2;
          push_o.r1 = sum_res;
          hdr_idx_d = '0;
          cnt_d     = '0;
          isum_d    = '0;
          osum_d    = '0;
          pin_d     = '0;
          pout_d    = '0;
          zero_d    = 1'b0;
        end else begin
          push_o.n = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_idx_q <= '0;
      op_q      <= '0;
      k_q       <= '0;
      rc_q      <= '0;
      len_hi_q  <= '0;
      len_m9_q  <= '0;
      cnt_q     <= '0;
      isum_q    <= '0;
      osum_q    <= '0;
      pin_q     <= '0;
      pout_q    <= '0;
      zero_q    <= 1'b0;
    end else begin
      hdr_idx_q <= hdr_idx_d;
      op_q      <= op_d;
      k_q       <= k_d;
      rc_q      <= rc_d;
      len_hi_q  <= len_hi_d;
      len_m9_q  <= len_m9_d;
      cnt_q     <= cnt_d;
      isum_q    <= isum_d;
      osum_q    <= osum_d;
      pin_q     <= pin_d;
      pout_q    <= pout_d;
      zero_q    <= zero_d;
    end
  end

endmodule

FILE: hdl/cpce_res_fifo.sv
module cpce_res_fifo
  import cpce_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign valid_o = (cnt_q != '0);
  assign res_o   = mem_q[rd_q];
  assign pop     = valid_o && ready_i;
  // keep space for the two results a single byte can produce
  assign room_o  = (cnt_q <= CntW'(Depth - 2));

  always_comb begin
    wr_d  = wr_q + PtrW'(push_i.n);
    rd_d  = pop ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.n) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_q + PtrW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: hdl/caesar_packet_checksum_engine.sv
// Caesar packet checksum engine: takes one message byte per transaction, 8 header bytes
// (op, shift, checksum little-endian, total length big-endian) then the payload. Every
// payload transaction returns its byte (kind 0), lowercased and rotated if it is a letter
// and before the first zero; the end of a message adds a summary (kind 1, last 1) with the
// recomputed checksum and a status, and a consumer must drop the payload when that status
// is not ok. A byte is taken every clock cycle while the result queue has room: its header or
// payload update is done in the cycle it is accepted and its results land in a four-entry
// result queue, so input ready drops only while the queue holds more than two results.
// The payload byte that ends a message yields two results, its own and the summary.
module caesar_packet_checksum_engine
  import cpce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  out_byte_o,
  output logic [15:0] new_checksum_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  push_t   push;
  result_t res;
  logic    accept;

  assign accept = in_valid_i && in_ready_o;

  cpce_msg_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .push_o      (push)
  );

  cpce_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res)
  );

  assign kind_o         = res.kind;
  assign out_byte_o     = res.out_byte;
  assign new_checksum_o = res.new_checksum;
  assign status_o       = res.status;
  assign last_o         = res.last;

endmodule

FILE: tb/cpce_cipher_checker.sv
module cpce_cipher_checker
  import cpce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        kind_i,
  input  logic [7:0]  out_byte_i,
  input  logic [15:0] new_checksum_i,
  input  logic [1:0]  status_i,
  input  logic        last_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned results_o
);

  localparam int Letters   = 26;
  localparam int AsciiUpA  = 65;
  localparam int AsciiUpZ  = 90;
  localparam int AsciiLowA = 97;
  localparam int AsciiLowZ = 122;
  localparam int CaseGap   = 32;

  // predicted engine state
  logic [3:0]  hdr_idx   = '0;
  logic [7:0]  op_q      = '0;
  logic [7:0]  shift_q   = '0;
  logic [15:0] rx_csum   = '0;
  logic [31:0] msg_len   = '0;
  logic [31:0] pay_cnt   = '0;
  logic [15:0] sum_in    = '0;
  logic [15:0] sum_out   = '0;
  logic [7:0]  held_in   = '0;
  logic [7:0]  held_out  = '0;
  logic        zero_hit  = 1'b0;

  result_t     cipher_results_q[$];
  result_t     want_r;
  int unsigned fails = 0;
  int unsigned seen = 0;

  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic logic [7:0] rotate(input logic [7:0] c);
    int k;
    int v;
    k = int'(shift_q) % Letters;
    v = int'(c);
    if (v >= AsciiUpA && v <= AsciiUpZ) begin
      v = v + CaseGap;
    end
    if (v >= AsciiLowA && v <= AsciiLowZ) begin
      if (op_q == 8'd0) begin
        v = (v - AsciiLowA + k) % Letters + AsciiLowA;
      end else begin
        v = (v - AsciiLowA + Letters - k) % Letters + AsciiLowA;
      end
    end
    return v[7:0];
  endfunction

  task automatic clear_message();
    hdr_idx  = '0;
    pay_cnt  = '0;
    sum_in   = '0;
    sum_out  = '0;
    held_in  = '0;
    held_out = '0;
    zero_hit = 1'b0;
  endtask

  task automatic seal_message();
    result_t     r;
    logic [15:0] total;
    // odd trailing byte still waiting for its partner
    if (pay_cnt[0] && !zero_hit) begin
      sum_in  = fold_add(sum_in, {8'd0, held_in});
      sum_out = fold_add(sum_out, {8'd0, held_out});
    end
    total = sum_in + rx_csum;
    if (total != 16'hFFFF) begin
      r.status = StCsumErr;
    end else if (zero_hit || msg_len != 32'(HdrLen) + pay_cnt) begin
      r.status = StLenErr;
    end else if (op_q > 8'd1) begin
      r.status = StOpErr;
    end else begin
      r.status = StOk;
    end
    r.kind         = KindSummary;
    r.out_byte     = 8'd0;
    r.new_checksum = ~sum_out;
    r.last         = 1'b1;
    cipher_results_q.push_back(r);
    clear_message();
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    result_t    r;
    logic [7:0] c;
    if (hdr_idx < 4'(HdrLen)) begin
      case (hdr_idx)
        4'd0: begin
          op_q   = b;
          sum_in = fold_add(sum_in, {8'd0, b});
        end
        4'd1: begin
          shift_q = b;
          sum_in  = fold_add(sum_in, {b, 8'd0});
        end
        4'd2: rx_csum = {8'd0, b};
        4'd3: rx_csum[15:8] = b;
        4'd4: begin
          msg_len = {b, 24'd0};
          sum_in  = fold_add(sum_in, {8'd0, b});
        end
        4'd5: begin
          msg_len[23:16] = b;
          sum_in = fold_add(sum_in, {b, 8'd0});
        end
        4'd6: begin
          msg_len[15:8] = b;
          sum_in = fold_add(sum_in, {8'd0, b});
        end
        default: begin
          msg_len[7:0] = b;
          sum_in = fold_add(sum_in, {b, 8'd0});
        end
      endcase
      hdr_idx = hdr_idx + 4'd1;
      if (hdr_idx == 4'(HdrLen)) begin
        sum_out = sum_in;
        if (msg_len <= 32'(HdrLen)) begin
          seal_message();
        end
      end
    end else begin
      if (zero_hit || b == 8'd0) begin
        // from the first zero on, bytes pass through and stay out of the sums
        c = b;
        if (!zero_hit && pay_cnt[0]) begin
          sum_in  = fold_add(sum_in, {8'd0, held_in});
          sum_out = fold_add(sum_out, {8'd0, held_out});
        end
        zero_hit = 1'b1;
      end else begin
        c = rotate(b);
        if (pay_cnt[0]) begin
          sum_in  = fold_add(sum_in, {b, held_in});
          sum_out = fold_add(sum_out, {c, held_out});
        end else begin
          held_in  = b;
          held_out = c;
        end
      end
      r.kind         = KindPayload;
      r.out_byte     = c;
      r.new_checksum = 16'd0;
      r.status       = StOk;
      r.last         = 1'b0;
      cipher_results_q.push_back(r);
      pay_cnt = pay_cnt + 32'd1;
      if (pay_cnt == msg_len - 32'(HdrLen)) begin
        seal_message();
      end
    end
  endtask

  task automatic note_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    fails++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    = '0;
      shift_q = '0;
      rx_csum = '0;
      msg_len = '0;
      clear_message();
      cipher_results_q.delete();
      pending_o    <= 0;
      fail_count_o <= fails;
      results_o    <= seen;
    end else begin
      if (in_valid_i && in_ready_i) begin
        absorb_byte(data_byte_i);
      end
      if (out_valid_i && out_ready_i) begin
        seen++;
        if (cipher_results_q.size() == 0) begin
          fails++;
          $display("%0t: result with nothing expected, expected none, actual kind %0h byte %0h",
                   $time, kind_i, out_byte_i);
        end else begin
          want_r = cipher_results_q.pop_front();
          if (kind_i !== want_r.kind) begin
            note_mismatch("kind", 32'(want_r.kind), 32'(kind_i));
          end
          if (out_byte_i !== want_r.out_byte) begin
            note_mismatch("out_byte", 32'(want_r.out_byte), 32'(out_byte_i));
          end
          if (new_checksum_i !== want_r.new_checksum) begin
            note_mismatch("new_checksum", 32'(want_r.new_checksum), 32'(new_checksum_i));
          end
          if (status_i !== want_r.status) begin
            note_mismatch("status", 32'(want_r.status), 32'(status_i));
          end
          if (last_i !== want_r.last) begin
            note_mismatch("last", 32'(want_r.last), 32'(last_i));
          end
        end
      end
      pending_o    <= cipher_results_q.size();
      fail_count_o <= fails;
      results_o    <= seen;
    end
  end

endmodule

FILE: tb/tb_caesar_packet_checksum_engine.sv
module tb_caesar_packet_checksum_engine;

  localparam int Limit      = 1000;
  localparam int TailCycles = 32;
  localparam int PhaseBytes = 450;
  localparam int IdlePct  [4] = '{0, 45, 0, 34};
  localparam int StallPct [4] = '{0, 0, 45, 34};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        kind_o;
  logic [7:0]  out_byte_o;
  logic [15:0] new_checksum_o;
  logic [1:0]  status_o;
  logic        last_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results;

  int idle_pct  = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int messages = 0;
  int quiet = 0;

  logic [7:0] payload_q[$];
  logic [7:0] demo_bytes [11];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  caesar_packet_checksum_engine i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .out_byte_o     (out_byte_o),
    .new_checksum_o (new_checksum_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  cpce_cipher_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_i         (kind_o),
    .out_byte_i     (out_byte_o),
    .new_checksum_i (new_checksum_o),
    .status_i       (status_o),
    .last_i         (last_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results)
  );

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= Limit) begin
        $display("watchdog: no transaction for %0d cycles", Limit);
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic put_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    bytes_sent++;
  endtask

  // checksum field that makes the header plus payload sum come out good
  function automatic logic [15:0] good_checksum(input logic [7:0] op, input logic [7:0] shift,
                                                input logic [31:0] len);
    logic [31:0] acc;
    logic [7:0]  lo;
    int          n;
    acc = {16'd0, shift, op} + {16'd0, len[23:16], len[31:24]} + {16'd0, len[7:0], len[15:8]};
    lo = 8'd0;
    n = 0;
    if (len > 32'd8) begin
      for (int i = 0; i < payload_q.size(); i++) begin
        if (payload_q[i] == 8'd0) begin
          break;
        end
        if (n % 2 == 0) begin
          lo = payload_q[i];
        end else begin
          acc = acc + {16'd0, payload_q[i], lo};
        end
        n++;
      end
      if (n % 2 == 1) begin
        acc = acc + {24'd0, lo};
      end
    end
    acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
    acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
    return ~acc[15:0];
  endfunction

  task automatic send_message(input logic [7:0] op, input logic [7:0] shift,
                              input logic [31:0] len, input logic fix_csum,
                              input logic [15:0] raw_csum);
    logic [15:0] csum;
    csum = fix_csum ? good_checksum(op, shift, len) : raw_csum;
    put_byte(op);
    put_byte(shift);
    put_byte(csum[7:0]);
    put_byte(csum[15:8]);
    put_byte(len[31:24]);
    put_byte(len[23:16]);
    put_byte(len[15:8]);
    put_byte(len[7:0]);
    for (int i = 0; i < payload_q.size(); i++) begin
      put_byte(payload_q[i]);
    end
    messages++;
  endtask

  task automatic send_random_message();
    int          pick;
    int          sel;
    int          plen;
    logic [7:0]  op;
    logic [7:0]  shift;
    logic [31:0] len;
    logic        fix;
    logic [15:0] raw;
    pick = $urandom_range(0, 99);
    sel = $urandom_range(0, 3);
    op = (sel < 2) ? 8'd0 : (sel == 2) ? 8'd1 : 8'($urandom_range(0, 255));
    shift = 8'($urandom_range(0, 255));
    sel = $urandom_range(0, 99);
    // mostly short payloads, a few long ones to make the len[15:8] byte nonzero
    if (sel < 80) begin
      plen = $urandom_range(1, 24);
    end else if (sel < 97) begin
      plen = $urandom_range(25, 64);
    end else begin
      plen = $urandom_range(65, 300);
    end
    payload_q.delete();
    for (int i = 0; i < plen; i++) begin
      if (pick >= 35 && pick < 40) begin
        payload_q.push_back(8'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 99) < 40) begin
        payload_q.push_back(8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + $urandom_range(0, 25)));
      end else begin
        payload_q.push_back(8'($urandom_range(1, 255)));
      end
    end
    len = 32'(8 + plen);
    fix = 1'b1;
    raw = 16'($urandom_range(0, 65535));
    if (pick < 15) begin
      // zero byte somewhere in the payload
      payload_q[$urandom_range(0, plen - 1)] = 8'd0;
    end else if (pick < 25) begin
      fix = 1'b0;
    end else if (pick < 35) begin
      len = 32'($urandom_range(0, 8));
      payload_q.delete();
    end else if (pick < 40) begin
      fix = 1'($urandom_range(0, 1));
    end
    send_message(op, shift, len, fix, raw);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // case folding, alphabet ends, non-letters, high bytes, odd count flushed by a zero
    demo_bytes = '{8'h41, 8'h5A, 8'h61, 8'h7A, 8'h40, 8'h7B, 8'hFF, 8'h80, 8'h6D, 8'h00,
                   8'h51};
    payload_q.delete();
    foreach (demo_bytes[i]) begin
      payload_q.push_back(demo_bytes[i]);
    end
    send_message(8'd0, 8'd255, 32'd19, 1'b1, 16'd0);
    // header only, unknown op, bad checksum
    payload_q.delete();
    send_message(8'd255, 8'd26, 32'd8, 1'b0, 16'd0);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = IdlePct[ph];
      stall_pct = StallPct[ph];
      while (bytes_sent < (ph + 1) * PhaseBytes) begin
        send_random_message();
      end
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);

    $display("run: %0d bytes in %0d messages, %0d results checked", bytes_sent, messages,
             results);
    $display("run: four sender/receiver idle mixes, %0d results still expected", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
